// ----- hw/rtl/gcsr_pkg.sv -----
// ----------------------------------------------------------------------------
// gcsr_pkg
// Shared types and codes of the graph list builder and arc query block.
// ----------------------------------------------------------------------------
package gcsr_pkg;

    localparam int KIND_W   = 2;
    localparam int NODE_W   = 10;
    localparam int TOTAL_W  = 13;
    localparam int STATUS_W = 2;

    // Stream widths: input tdata carries node_a then node_b, output tdata
    // carries found then arc_total, both filled up to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUILD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } cmd_t;

    typedef struct packed {
        logic                found;
        logic [TOTAL_W-1:0]  arc_total;
        logic [STATUS_W-1:0] status;
    } res_t;

    typedef struct packed {
        logic [NODE_W-1:0] lo;
        logic [NODE_W-1:0] hi;
    } arc_t;

endpackage

// ----- hw/rtl/gcsr_core.sv -----
// ----------------------------------------------------------------------------
// gcsr_core
// Edge, degree, offset and neighbor memories with the sequencer that loads
// arcs, builds sorted distinct neighbor lists and answers arc queries.
// ----------------------------------------------------------------------------
module gcsr_core #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  gcsr_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output gcsr_pkg::res_t res
);
    import gcsr_pkg::*;

    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int EIW = $clog2(MAX_EDGES);
    localparam int NIW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);

    localparam logic [4:0] S_CLR        = 5'd0;
    localparam logic [4:0] S_IDLE       = 5'd1;
    localparam logic [4:0] S_CNT_RD     = 5'd2;
    localparam logic [4:0] S_CNT_E      = 5'd3;
    localparam logic [4:0] S_CNT_W      = 5'd4;
    localparam logic [4:0] S_PFX_RD     = 5'd5;
    localparam logic [4:0] S_PFX_W      = 5'd6;
    localparam logic [4:0] S_FILL_RD    = 5'd7;
    localparam logic [4:0] S_FILL_E     = 5'd8;
    localparam logic [4:0] S_FILL_W     = 5'd9;
    localparam logic [4:0] S_SRT_NODE   = 5'd10;
    localparam logic [4:0] S_SRT_LD     = 5'd11;
    localparam logic [4:0] S_INS_KEY    = 5'd12;
    localparam logic [4:0] S_INS_KW     = 5'd13;
    localparam logic [4:0] S_INS_CMP_RD = 5'd14;
    localparam logic [4:0] S_INS_CMP    = 5'd15;
    localparam logic [4:0] S_DD_RD      = 5'd16;
    localparam logic [4:0] S_DD_W       = 5'd17;
    localparam logic [4:0] S_Q_LD       = 5'd18;
    localparam logic [4:0] S_Q_RD       = 5'd19;
    localparam logic [4:0] S_Q_CMP      = 5'd20;
    localparam logic [4:0] S_DONE       = 5'd21;

    // Memories: one write and one registered read port each.
    arc_t              edge_mem [MAX_EDGES];
    logic [CW-1:0]     deg_mem  [MAX_NODES];
    logic [CW-1:0]     off_mem  [MAX_NODES];
    logic [NODE_W-1:0] nbr_mem  [MAX_EDGES];

    logic              edge_we, deg_we, off_we, nbr_we;
    logic [EIW-1:0]    edge_waddr, edge_raddr, nbr_waddr, nbr_raddr;
    logic [NIW-1:0]    deg_waddr, deg_raddr, off_waddr, off_raddr;
    arc_t              edge_wdata, edge_rd;
    logic [CW-1:0]     deg_wdata, deg_rd, off_wdata, off_rd;
    logic [NODE_W-1:0] nbr_wdata, nbr_rd;

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rd <= edge_mem[edge_raddr];
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_rd <= deg_mem[deg_raddr];
    end

    always_ff @(posedge aclk) begin
        if (off_we) begin
            off_mem[off_waddr] <= off_wdata;
        end
        off_rd <= off_mem[off_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nbr_we) begin
            nbr_mem[nbr_waddr] <= nbr_wdata;
        end
        nbr_rd <= nbr_mem[nbr_raddr];
    end

    logic [4:0]        state_reg, state_next;
    logic [CW-1:0]     edges_loaded_reg, edges_loaded_next;
    logic              built_reg, built_next;
    logic [CW-1:0]     i_reg, i_next, j_reg, j_next, w_reg, w_next;
    logic [CW-1:0]     start_reg, start_next, raw_reg, raw_next;
    logic [CW-1:0]     sum_reg, sum_next, total_reg, total_next;
    logic [CW-1:0]     lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [NCW-1:0]    n_reg, n_next;
    logic [NODE_W-1:0] key_reg, key_next, last_reg, last_next, y_reg, y_next;
    arc_t              arc_reg, arc_next;
    logic              qzero_reg, qzero_next;
    res_t              res_reg, res_next;

    logic [NODE_W-1:0] qx, qy;
    logic              a_bad, b_bad, x_bad, go_build, go_query, accept;
    logic [CW-1:0]     mid_calc;
    res_t              imm;

    assign qx    = (cmd.node_a < cmd.node_b) ? cmd.node_a : cmd.node_b;
    assign qy    = (cmd.node_a < cmd.node_b) ? cmd.node_b : cmd.node_a;
    assign a_bad = (32'(cmd.node_a) >= MAX_NODES);
    assign b_bad = (32'(cmd.node_b) >= MAX_NODES);
    assign x_bad = (32'(qx) >= MAX_NODES);

    assign go_build = (cmd.kind == KIND_BUILD) && !built_reg;
    assign go_query = (cmd.kind == KIND_QUERY) && built_reg && !x_bad;

    // Items answered in the cycle they are taken.
    always_comb begin
        imm = '0;
        case (cmd.kind)
            KIND_LOAD: begin
                if (built_reg || a_bad || b_bad) begin
                    imm.status = STATUS_REJECT;
                end else if (cmd.node_a != cmd.node_b &&
                             32'(edges_loaded_reg) >= MAX_EDGES) begin
                    imm.status = STATUS_FULL;
                end
            end
            KIND_BUILD: imm.status = STATUS_REJECT;
            KIND_QUERY: imm.status = built_reg ? STATUS_OK : STATUS_REJECT;
            default:    imm.status = STATUS_REJECT;
        endcase
    end

    assign cmd_ready = (state_reg == S_IDLE) && (go_build || go_query || res_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = (state_reg == S_DONE) ||
                       ((state_reg == S_IDLE) && cmd_valid && !go_build && !go_query);
    assign res       = (state_reg == S_DONE) ? res_reg : imm;
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb begin
        state_next        = state_reg;
        edges_loaded_next = edges_loaded_reg;
        built_next        = built_reg;
        i_next     = i_reg;     j_next     = j_reg;     w_next   = w_reg;
        start_next = start_reg; raw_next   = raw_reg;   sum_next = sum_reg;
        total_next = total_reg; lo_next    = lo_reg;    hi_next  = hi_reg;
        mid_next   = mid_reg;   n_next     = n_reg;     key_next = key_reg;
        last_next  = last_reg;  y_next     = y_reg;     arc_next = arc_reg;
        qzero_next = qzero_reg; res_next   = res_reg;

        edge_we = 1'b0; edge_waddr = '0; edge_wdata = '0; edge_raddr = '0;
        deg_we  = 1'b0; deg_waddr  = '0; deg_wdata  = '0; deg_raddr  = '0;
        off_we  = 1'b0; off_waddr  = '0; off_wdata  = '0; off_raddr  = '0;
        nbr_we  = 1'b0; nbr_waddr  = '0; nbr_wdata  = '0; nbr_raddr  = '0;

        case (state_reg)
            S_CLR: begin
                deg_we    = 1'b1;
                deg_waddr = NIW'(n_reg);
                if (32'(n_reg) == MAX_NODES - 1) begin
                    state_next = S_IDLE;
                end
                n_next = n_reg + 1'b1;
            end
            S_IDLE: begin
                deg_raddr = NIW'(qx);
                off_raddr = NIW'(qx - 1'b1);
                if (accept) begin
                    if (go_build) begin
                        i_next     = '0;
                        state_next = S_CNT_RD;
                    end else if (go_query) begin
                        qzero_next = (qx == '0);
                        y_next     = qy;
                        state_next = S_Q_LD;
                    end else if (cmd.kind == KIND_LOAD && imm.status == STATUS_OK &&
                                 cmd.node_a != cmd.node_b) begin
                        edge_we           = 1'b1;
                        edge_waddr        = edges_loaded_reg[EIW-1:0];
                        edge_wdata.lo     = qx;
                        edge_wdata.hi     = qy;
                        edges_loaded_next = edges_loaded_reg + 1'b1;
                    end
                end
            end
            // Degree count: each arc passes an edge read, a degree read and a write state,
            // so each increment is written before the next read of the same node.
            S_CNT_RD: begin
                edge_raddr = i_reg[EIW-1:0];
                if (i_reg == edges_loaded_reg) begin
                    n_next     = '0;
                    sum_next   = '0;
                    state_next = S_PFX_RD;
                end else begin
                    state_next = S_CNT_E;
                end
            end
            S_CNT_E: begin
                arc_next   = edge_rd;
                deg_raddr  = NIW'(edge_rd.lo);
                state_next = S_CNT_W;
            end
            S_CNT_W: begin
                deg_we     = 1'b1;
                deg_waddr  = NIW'(arc_reg.lo);
                deg_wdata  = deg_rd + 1'b1;
                i_next     = i_reg + 1'b1;
                state_next = S_CNT_RD;
            end
            S_PFX_RD: begin
                deg_raddr = NIW'(n_reg);
                if (32'(n_reg) == MAX_NODES) begin
                    i_next     = '0;
                    state_next = S_FILL_RD;
                end else begin
                    state_next = S_PFX_W;
                end
            end
            S_PFX_W: begin
                off_we     = 1'b1;
                off_waddr  = NIW'(n_reg);
                off_wdata  = sum_reg;
                sum_next   = sum_reg + deg_rd;
                n_next     = n_reg + 1'b1;
                state_next = S_PFX_RD;
            end
            // The offset entry serves as the fill pointer; once filled it
            // holds the start of the following node's list.
            S_FILL_RD: begin
                edge_raddr = i_reg[EIW-1:0];
                if (i_reg == edges_loaded_reg) begin
                    n_next     = '0;
                    total_next = '0;
                    state_next = S_SRT_NODE;
                end else begin
                    state_next = S_FILL_E;
                end
            end
            S_FILL_E: begin
                arc_next   = edge_rd;
                off_raddr  = NIW'(edge_rd.lo);
                state_next = S_FILL_W;
            end
            S_FILL_W: begin
                nbr_we     = 1'b1;
                nbr_waddr  = off_rd[EIW-1:0];
                nbr_wdata  = arc_reg.hi;
                off_we     = 1'b1;
                off_waddr  = NIW'(arc_reg.lo);
                off_wdata  = off_rd + 1'b1;
                i_next     = i_reg + 1'b1;
                state_next = S_FILL_RD;
            end
            S_SRT_NODE: begin
                deg_raddr = NIW'(n_reg);
                off_raddr = NIW'(n_reg - 1'b1);
                if (32'(n_reg) == MAX_NODES) begin
                    res_next.found     = 1'b0;
                    res_next.arc_total = TOTAL_W'(total_reg);
                    res_next.status    = STATUS_OK;
                    built_next         = 1'b1;
                    state_next         = S_DONE;
                end else begin
                    state_next = S_SRT_LD;
                end
            end
            S_SRT_LD: begin
                start_next = (n_reg == '0) ? '0 : off_rd;
                raw_next   = deg_rd;
                i_next     = CW'(1);
                state_next = S_INS_KEY;
            end
            S_INS_KEY: begin
                nbr_raddr = EIW'(start_reg + i_reg);
                j_next    = i_reg;
                if (i_reg >= raw_reg) begin
                    i_next     = '0;
                    w_next     = '0;
                    state_next = S_DD_RD;
                end else begin
                    state_next = S_INS_KW;
                end
            end
            S_INS_KW: begin
                key_next   = nbr_rd;
                state_next = S_INS_CMP_RD;
            end
            S_INS_CMP_RD: begin
                nbr_raddr = EIW'(start_reg + j_reg - 1'b1);
                if (j_reg == '0) begin
                    nbr_we     = 1'b1;
                    nbr_waddr  = start_reg[EIW-1:0];
                    nbr_wdata  = key_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_INS_KEY;
                end else begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                nbr_we    = 1'b1;
                nbr_waddr = EIW'(start_reg + j_reg);
                if (nbr_rd > key_reg) begin
                    nbr_wdata  = nbr_rd;
                    j_next     = j_reg - 1'b1;
                    state_next = S_INS_CMP_RD;
                end else begin
                    nbr_wdata  = key_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_INS_KEY;
                end
            end
            S_DD_RD: begin
                nbr_raddr = EIW'(start_reg + i_reg);
                if (i_reg == raw_reg) begin
                    deg_we     = 1'b1;
                    deg_waddr  = NIW'(n_reg);
                    deg_wdata  = w_reg;
                    total_next = total_reg + w_reg;
                    n_next     = n_reg + 1'b1;
                    state_next = S_SRT_NODE;
                end else begin
                    state_next = S_DD_W;
                end
            end
            S_DD_W: begin
                if (w_reg == '0 || last_reg != nbr_rd) begin
                    nbr_we    = 1'b1;
                    nbr_waddr = EIW'(start_reg + w_reg);
                    nbr_wdata = nbr_rd;
                    last_next = nbr_rd;
                    w_next    = w_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_DD_RD;
            end
            S_Q_LD: begin
                lo_next    = qzero_reg ? '0 : off_rd;
                hi_next    = (qzero_reg ? '0 : off_rd) + deg_rd;
                state_next = S_Q_RD;
            end
            S_Q_RD: begin
                nbr_raddr = mid_calc[EIW-1:0];
                mid_next  = mid_calc;
                if (lo_reg >= hi_reg) begin
                    res_next   = '0;
                    state_next = S_DONE;
                end else begin
                    state_next = S_Q_CMP;
                end
            end
            S_Q_CMP: begin
                if (nbr_rd == y_reg) begin
                    res_next       = '0;
                    res_next.found = 1'b1;
                    state_next     = S_DONE;
                end else begin
                    if (nbr_rd < y_reg) begin
                        lo_next = mid_reg + 1'b1;
                    end else begin
                        hi_next = mid_reg;
                    end
                    state_next = S_Q_RD;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLR;
            n_reg            <= '0;
            edges_loaded_reg <= '0;
            built_reg        <= 1'b0;
        end else begin
            state_reg        <= state_next;
            n_reg            <= n_next;
            edges_loaded_reg <= edges_loaded_next;
            built_reg        <= built_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg     <= i_next;     j_reg     <= j_next;     w_reg   <= w_next;
        start_reg <= start_next; raw_reg   <= raw_next;   sum_reg <= sum_next;
        total_reg <= total_next; lo_reg    <= lo_next;    hi_reg  <= hi_next;
        mid_reg   <= mid_next;   key_reg   <= key_next;   last_reg <= last_next;
        y_reg     <= y_next;     arc_reg   <= arc_next;   qzero_reg <= qzero_next;
        res_reg   <= res_next;
    end

endmodule

// ----- hw/rtl/graph_csr_builder_and_edge_query.sv -----
// ----------------------------------------------------------------------------
// graph_csr_builder_and_edge_query
// Undirected edge loader, sorted neighbor list builder and arc query.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ stream; kind in s_tuser selects a load, a
// build or a query. Every item gives exactly one transfer on the m_ stream.
// A load, and any rejected item, is answered at the edge that takes it, so
// m_tvalid rises in the cycle after, and loads sustain one transfer per cycle
// while the receiver keeps m_tready high. A build walks the memories: it
// counts the loaded arcs per node, forms the prefix sum of the degrees and
// fills the lists, then per node runs an insertion sort and a duplicate
// removal, both bound by the single read port of the neighbor memory. A
// query loads the bounds of the lower node's list and binary-searches it
// for the other node until it is found or the range is empty.
// After reset the block clears the degree memory, one entry a cycle, over
// all MAX_NODES entries, with s_tready low. When the receiver stalls, the
// result holds in the output register; one more load can be taken only once
// it drains, and build or query results wait inside the block.
// ----------------------------------------------------------------------------
module graph_csr_builder_and_edge_query #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // node_a [9:0], node_b [19:10], zero fill
    input  logic [gcsr_pkg::S_TDATA_W-1:0]       s_tdata,
    // kind [1:0]
    input  logic [gcsr_pkg::KIND_W-1:0]          s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // found [0], arc_total [13:1], zero fill
    output logic [gcsr_pkg::M_TDATA_W-1:0]       m_tdata,
    // status [1:0]
    output logic [gcsr_pkg::STATUS_W-1:0]        m_tuser
);
    import gcsr_pkg::*;

    cmd_t cmd;
    res_t core_res;
    res_t out_reg;
    logic out_valid_reg;
    logic core_res_valid, res_ready;

    assign cmd.kind   = s_tuser;
    assign cmd.node_a = s_tdata[NODE_W-1:0];
    assign cmd.node_b = s_tdata[2*NODE_W-1:NODE_W];

    assign res_ready = !out_valid_reg || m_tready;

    gcsr_core #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (core_res_valid),
        .res_ready (res_ready),
        .res       (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= core_res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && core_res_valid) begin
            out_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.arc_total, out_reg.found});
    assign m_tuser  = out_reg.status;

endmodule

// ----- hw/rtl/gcsr_checker.sv -----
// ----------------------------------------------------------------------------
// gcsr_checker
// Port-level checks of the graph list builder, attached to the top level.
// ----------------------------------------------------------------------------
module gcsr_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [gcsr_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [gcsr_pkg::STATUS_W-1:0]      m_tuser
);
    import gcsr_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result transfer changed");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A found arc only comes from a successful query.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tuser == STATUS_OK && m_tdata[13:1] == '0)
        else $error("found set on a result that is not a clean query");

    // An arc count only comes from a successful build.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13:1] != '0 |-> m_tuser == STATUS_OK)
        else $error("arc count on a failed item");

    // Status never carries an unused code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == STATUS_OK || m_tuser == STATUS_FULL ||
                     m_tuser == STATUS_REJECT)
        else $error("unused status code");

endmodule

bind graph_csr_builder_and_edge_query gcsr_checker u_gcsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/graph_csr_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_csr_checker
// Watches both streams of the graph list builder, keeps its own copy of the
// arc store and the built lists, and compares every result transfer.
// ----------------------------------------------------------------------------
module graph_csr_checker #(
    parameter int NODE_CAP = 1024,
    parameter int EDGE_CAP = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [gcsr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [gcsr_pkg::KIND_W-1:0]      s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [gcsr_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [gcsr_pkg::STATUS_W-1:0]    m_tuser,
    output int                               fail_count,
    output int                               pending
);
    import gcsr_pkg::*;

    arc_t              arcs_held [EDGE_CAP];
    int                arcs_loaded;
    int                degree [NODE_CAP];
    int                list_start [NODE_CAP+1];
    logic [NODE_W-1:0] neighbors [EDGE_CAP];
    bit                lists_ready;
    res_t              expected_answers [$];

    initial begin
        arcs_loaded = 0;
        lists_ready = 0;
        fail_count  = 0;
        pending     = 0;
        for (int n = 0; n < NODE_CAP; n++) degree[n] = 0;
    end

    // Counts, prefix sum, fill, then per-list insertion sort and dedup.
    function automatic int build_lists();
        int fill [NODE_CAP];
        int total;
        int s, len, w, j;
        logic [NODE_W-1:0] key;
        total = 0;
        for (int n = 0; n < NODE_CAP; n++) begin
            degree[n] = 0;
            fill[n] = 0;
        end
        for (int i = 0; i < arcs_loaded; i++) degree[arcs_held[i].lo]++;
        list_start[0] = 0;
        for (int n = 0; n < NODE_CAP; n++) list_start[n+1] = list_start[n] + degree[n];
        for (int i = 0; i < arcs_loaded; i++) begin
            neighbors[list_start[arcs_held[i].lo] + fill[arcs_held[i].lo]] = arcs_held[i].hi;
            fill[arcs_held[i].lo]++;
        end
        for (int n = 0; n < NODE_CAP; n++) begin
            s = list_start[n];
            len = degree[n];
            for (int i = 1; i < len; i++) begin
                key = neighbors[s+i];
                j = i;
                while (j > 0 && neighbors[s+j-1] > key) begin
                    neighbors[s+j] = neighbors[s+j-1];
                    j--;
                end
                neighbors[s+j] = key;
            end
            w = 0;
            for (int i = 0; i < len; i++) begin
                if (w == 0 || neighbors[s+w-1] != neighbors[s+i]) begin
                    neighbors[s+w] = neighbors[s+i];
                    w++;
                end
            end
            degree[n] = w;
            total += w;
        end
        return total;
    endfunction

    function automatic bit arc_present(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        logic [NODE_W-1:0] x, y;
        int lo, hi, mid;
        x = (a < b) ? a : b;
        y = (a < b) ? b : a;
        if (x >= NODE_CAP) return 0;
        lo = list_start[x];
        hi = lo + degree[x];
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (neighbors[mid] == y) return 1;
            if (neighbors[mid] < y) lo = mid + 1;
            else hi = mid;
        end
        return 0;
    endfunction

    function automatic res_t predict_answer(logic [KIND_W-1:0] kind,
                                            logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        res_t r;
        r = '0;
        r.status = STATUS_OK;
        case (kind)
            KIND_LOAD: begin
                if (lists_ready || a >= NODE_CAP || b >= NODE_CAP) begin
                    r.status = STATUS_REJECT;
                end else if (a != b) begin
                    if (arcs_loaded >= EDGE_CAP) begin
                        r.status = STATUS_FULL;
                    end else begin
                        arcs_held[arcs_loaded].lo = (a < b) ? a : b;
                        arcs_held[arcs_loaded].hi = (a < b) ? b : a;
                        arcs_loaded++;
                    end
                end
            end
            KIND_BUILD: begin
                if (lists_ready) begin
                    r.status = STATUS_REJECT;
                end else begin
                    r.arc_total = TOTAL_W'(build_lists());
                    lists_ready = 1;
                end
            end
            KIND_QUERY: begin
                if (!lists_ready) r.status = STATUS_REJECT;
                else r.found = arc_present(a, b);
            end
            default: r.status = STATUS_REJECT;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t want, got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_answers.push_back(predict_answer(s_tuser, s_tdata[NODE_W-1:0],
                                                          s_tdata[2*NODE_W-1:NODE_W]));
            if (m_tvalid && m_tready) begin
                got.found     = m_tdata[0];
                got.arc_total = m_tdata[TOTAL_W:1];
                got.status    = m_tuser;
                if (expected_answers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result found=%0d total=%0d status=%0d",
                                 $realtime, got.found, got.arc_total, got.status);
                end else begin
                    want = expected_answers.pop_front();
                    if (got.found !== want.found || got.arc_total !== want.arc_total ||
                        got.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch expected found=%0d total=%0d ",
                                      "status=%0d, got found=%0d total=%0d status=%0d"},
                                     $realtime, want.found, want.arc_total, want.status,
                                     got.found, got.arc_total, got.status);
                    end
                end
            end
            pending = expected_answers.size();
        end
    end

endmodule

// ----- tb/graph_csr_builder_and_edge_query_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_csr_builder_and_edge_query_test
// Loads edges until the (reduced) arc store overflows, builds the lists once,
// then queries arcs, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module graph_csr_builder_and_edge_query_test;
    import gcsr_pkg::*;

    localparam int NODE_CAP = 1024;
    localparam int EDGE_CAP = 256;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    int                   fail_count;
    int                   pending;

    bit   send_calm, recv_calm, hold_off;
    int   loads_sent;
    arc_t loaded_arcs [$];

    graph_csr_builder_and_edge_query #(.MAX_NODES(NODE_CAP), .MAX_EDGES(EDGE_CAP)) dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    graph_csr_checker #(.NODE_CAP(NODE_CAP), .EDGE_CAP(EDGE_CAP)) u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .fail_count, .pending
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Stretches of heavy idling alternate with stretches of none.
    always begin
        repeat ($urandom_range(50, 250)) @(posedge aclk);
        send_calm = ($urandom_range(0, 3) == 0);
        recv_calm = ($urandom_range(0, 3) == 0);
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge aclk) begin
        int stall_left;
        if (hold_off) begin
            m_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 0;
        end else begin
            stall_left = pick_gap(recv_calm);
            m_tready <= (stall_left == 0);
        end
    end

    // One long receiver hold-off while loads keep coming.
    initial begin
        hold_off = 0;
        wait (loads_sent >= 40);
        hold_off = 1;
        repeat (300) @(posedge aclk);
        hold_off = 0;
    end

    // Entered just after a rising edge; leaves just after the accepting edge.
    task automatic send_item(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] a,
                             logic [NODE_W-1:0] b);
        int gap;
        gap = pick_gap(send_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-2*NODE_W){1'b0}}, b, a};
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_LOAD) begin
            loads_sent++;
            if (a != b) loaded_arcs.push_back('{lo: a, hi: b});
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        logic [NODE_W-1:0] a, b;
        arc_t pick;
        int r;
        loads_sent = 0;
        send_calm = 0;
        recv_calm = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: wrong-phase items, extremes, self-loop, reversed duplicate.
        send_item(KIND_QUERY, 10'd1, 10'd2);
        send_item(KIND_UNUSED, 10'd0, 10'd0);
        send_item(KIND_LOAD, 10'd7, 10'd7);
        send_item(KIND_LOAD, 10'd0, 10'd1023);
        send_item(KIND_LOAD, 10'd1023, 10'd0);
        send_item(KIND_LOAD, 10'd1023, 10'd1022);
        send_item(KIND_LOAD, 10'd0, 10'd1);
        send_item(KIND_LOAD, 10'd1, 10'd0);

        // Loads past the store size so that the full case shows up repeatedly.
        for (int i = 0; i < 290; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                a = NODE_W'($urandom_range(0, 15));
                b = NODE_W'($urandom_range(0, 15));
            end else if (r < 90) begin
                a = NODE_W'($urandom_range(0, 1023));
                b = NODE_W'($urandom_range(0, 1023));
            end else begin
                a = NODE_W'($urandom_range(0, 1023));
                b = a;
            end
            send_item(KIND_LOAD, a, b);
        end

        drain_results();
        send_item(KIND_BUILD, 10'd0, 10'd0);
        send_item(KIND_BUILD, 10'd1023, 10'd1023);
        send_item(KIND_LOAD, 10'd2, 10'd3);
        send_item(KIND_UNUSED, 10'd1023, 10'd1023);
        drain_results();

        send_item(KIND_QUERY, 10'd0, 10'd1023);
        send_item(KIND_QUERY, 10'd1023, 10'd0);
        send_item(KIND_QUERY, 10'd1022, 10'd1023);
        send_item(KIND_QUERY, 10'd5, 10'd5);
        send_item(KIND_QUERY, 10'd1023, 10'd1023);
        send_item(KIND_QUERY, 10'd0, 10'd0);

        for (int i = 0; i < 160; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                pick = loaded_arcs[$urandom_range(0, loaded_arcs.size() - 1)];
                if (r < 25) send_item(KIND_QUERY, pick.lo, pick.hi);
                else send_item(KIND_QUERY, pick.hi, pick.lo);
            end else if (r < 75) begin
                send_item(KIND_QUERY, NODE_W'($urandom_range(0, 15)),
                          NODE_W'($urandom_range(0, 15)));
            end else if (r < 95) begin
                send_item(KIND_QUERY, NODE_W'($urandom_range(0, 1023)),
                          NODE_W'($urandom_range(0, 1023)));
            end else begin
                send_item($urandom_range(0, 1) ? KIND_UNUSED : KIND_LOAD,
                          NODE_W'($urandom_range(0, 1023)),
                          NODE_W'($urandom_range(0, 1023)));
            end
        end

        drain_results();
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("graph_csr_builder_and_edge_query_test passed");
        else
            $display("graph_csr_builder_and_edge_query_test failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("graph_csr_builder_and_edge_query_test failed");
        $finish;
    end

endmodule
